// ----- hw/rtl/smx_pkg.sv -----
// Shared constants, codes and types for the stack machine executor.
`timescale 1ns / 1ps

package smx_pkg;

    // Operand stack geometry
    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Field widths on the stream ports
    localparam int WORD_W      = 32;
    localparam int ACT_W       = 4;
    localparam int STAT_W      = 3;
    localparam int DEPTH_W     = 9;
    localparam int OUT_FIELD_W = WORD_W + DEPTH_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Divider iteration counter width
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    // Opcodes
    localparam logic [ACT_W-1:0] OP_NONE = 4'd0;
    localparam logic [ACT_W-1:0] OP_PUSH = 4'd1;
    localparam logic [ACT_W-1:0] OP_POP  = 4'd2;
    localparam logic [ACT_W-1:0] OP_ADD  = 4'd3;
    localparam logic [ACT_W-1:0] OP_SUB  = 4'd4;
    localparam logic [ACT_W-1:0] OP_MUL  = 4'd5;
    localparam logic [ACT_W-1:0] OP_DIV  = 4'd6;
    localparam logic [ACT_W-1:0] OP_MOD  = 4'd7;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd4;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV,
        S_DIVFIX,
        S_WB,
        S_FIN
    } t_state;

endpackage

// ----- hw/rtl/smx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- hw/rtl/stack_machine_executor.sv -----
// Top level of the stack machine executor: sequencer, ALU, divider, stack RAM.
`timescale 1ns / 1ps

// Usage
//   Slave channel: one instruction per request. tuser carries the opcode,
//   tdata the value for a push (ignored by the other opcodes).
//   Master channel: one result per instruction. tuser carries the status,
//   tdata the new top of stack (zero when empty) and the stack depth.
//   Path, request accepted to result valid: none, push, pop, add, sub and any
//   error or halted reply go from decode to finish; mul adds a multiply and a
//   write-back state; div and mod run the bit-per-cycle restoring divider
//   (32 steps) plus sign fix and write-back. The block works on one
//   instruction at a time; the next request is taken only once the result is
//   loaded and the sequencer is back in idle.
//   The stack top is held in a register; the entry below it is read from
//   the stack RAM in the cycle a request is accepted, so RAM reads and
//   writes never overlap on one entry.
//   Reset empties the stack and clears the halt flag; stack RAM contents
//   are not cleared (only written entries are ever used).
//   Any error halts the block; every later request returns status halted
//   until reset. A stalled receiver holds the result in the output
//   register; the block still takes a new request and parks its result in
//   the finish state until the output register is free.

module stack_machine_executor
    import smx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request: [3:0] action
    input  logic [ACT_W-1:0]        i_s_tuser,
    // request: [31:0] push_value
    input  logic [WORD_W-1:0]       i_s_tdata,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // result: [2:0] status
    output logic [STAT_W-1:0]       o_m_tuser,
    // result: [31:0] top_value, [40:32] stack_depth, [47:41] zero
    output logic [OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready
);

    // control registers
    t_state               r_state, n_state;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic                 r_halted, n_halted;
    logic                 r_out_valid, n_out_valid;

    // payload registers
    logic [ACT_W-1:0]     r_act, n_act;
    logic [WORD_W-1:0]    r_val, n_val;
    logic [WORD_W-1:0]    r_top, n_top;
    logic [WORD_W-1:0]    r_a, n_a;       // operand a, quotient during divide
    logic [WORD_W-1:0]    r_b, n_b;       // operand b, divisor magnitude
    logic [WORD_W-1:0]    r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_na, n_na;
    logic                 r_nb, n_nb;
    logic [WORD_W-1:0]    r_res, n_res;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [STAT_W-1:0]    r_out_user, n_out_user;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // stack RAM port
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [WORD_W-1:0]    w_wdata;
    logic                 w_re;
    logic [ADDR_W-1:0]    w_raddr;
    logic [WORD_W-1:0]    w_rdata;

    // datapath helpers
    logic [SP_W-1:0]      w_sp_m1;
    logic [SP_W-1:0]      w_sp_m2;
    logic [WORD_W:0]      w_shift;
    logic [WORD_W:0]      w_diff;
    logic [WORD_W-1:0]    w_top_out;

    smx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_user;
    assign o_m_tdata  = r_out_data;

    assign w_sp_m1 = r_sp - SP_W'(1);
    assign w_sp_m2 = r_sp - SP_W'(2);

    // one restoring divide step: dividend bits shift out of r_a into the remainder, quotient bits shift in
    assign w_shift = {r_rem, r_a[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_b};

    assign w_top_out = (r_sp == '0) ? '0 : r_top;

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_halted    = r_halted;
        n_out_valid = r_out_valid;
        n_act       = r_act;
        n_val       = r_val;
        n_top       = r_top;
        n_a         = r_a;
        n_b         = r_b;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_na        = r_na;
        n_nb        = r_nb;
        n_res       = r_res;
        n_status    = r_status;
        n_out_user  = r_out_user;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = w_sp_m2[ADDR_W-1:0];
        w_wdata     = r_res;
        w_re        = 1'b0;
        w_raddr     = w_sp_m2[ADDR_W-1:0];

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // fetch the entry under the top while the request is latched
                w_re = 1'b1;
                if (i_s_tvalid) begin
                    n_act   = i_s_tuser;
                    n_val   = i_s_tdata;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_status = ST_OK;
                n_state  = S_FIN;
                if (r_halted) begin
                    n_status = ST_HALTED;
                end else begin
                    case (r_act)
                        OP_NONE: begin
                            n_status = ST_OK;
                        end
                        OP_PUSH: begin
                            if (r_sp == SP_W'(STACK_DEPTH)) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_sp[ADDR_W-1:0];
                                w_wdata = r_val;
                                n_top   = r_val;
                                n_sp    = r_sp + SP_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_sp == '0) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_top = w_rdata;
                                n_sp  = w_sp_m1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                            if (r_sp < SP_W'(2)) begin
                                n_status = ST_UNDERFLOW;
                            end else if ((r_act == OP_DIV || r_act == OP_MOD) &&
                                         r_top == '0) begin
                                n_status = ST_DIVZERO;
                            end else if (r_act == OP_ADD || r_act == OP_SUB) begin
                                w_we    = 1'b1;
                                w_wdata = (r_act == OP_ADD) ? (w_rdata + r_top)
                                                            : (w_rdata - r_top);
                                n_top   = w_wdata;
                                n_sp    = w_sp_m1;
                            end else if (r_act == OP_MUL) begin
                                n_a     = w_rdata;
                                n_b     = r_top;
                                n_state = S_MUL;
                            end else begin
                                // divide on magnitudes, signs applied at the end
                                n_na    = w_rdata[WORD_W-1];
                                n_nb    = r_top[WORD_W-1];
                                n_a     = w_rdata[WORD_W-1] ? (~w_rdata + WORD_W'(1))
                                                            : w_rdata;
                                n_b     = r_top[WORD_W-1] ? (~r_top + WORD_W'(1)) : r_top;
                                n_rem   = '0;
                                n_cnt   = '0;
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                        end
                    endcase
                    if (n_status != ST_OK) begin
                        n_halted = 1'b1;
                    end
                end
            end

            S_MUL: begin
                n_res   = r_a * r_b;
                n_state = S_WB;
            end

            S_DIV: begin
                if (!w_diff[WORD_W]) begin
                    n_rem = w_diff[WORD_W-1:0];
                    n_a   = {r_a[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[WORD_W-1:0];
                    n_a   = {r_a[WORD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                    n_state = S_DIVFIX;
                end
            end

            S_DIVFIX: begin
                if (r_act == OP_DIV) begin
                    n_res = (r_na != r_nb) ? (~r_a + WORD_W'(1)) : r_a;
                end else begin
                    n_res = r_na ? (~r_rem + WORD_W'(1)) : r_rem;
                end
                n_state = S_WB;
            end

            S_WB: begin
                w_we    = 1'b1;
                w_wdata = r_res;
                n_top   = r_res;
                n_sp    = w_sp_m1;
                n_state = S_FIN;
            end

            S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_status;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, DEPTH_W'(r_sp), w_top_out};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_val      <= n_val;
        r_top      <= n_top;
        r_a        <= n_a;
        r_b        <= n_b;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_na       <= n_na;
        r_nb       <= n_nb;
        r_res      <= n_res;
        r_status   <= n_status;
        r_out_user <= n_out_user;
        r_out_data <= n_out_data;
    end

endmodule

// ----- sim/stack_machine_executor_tb.sv -----
// Self-checking testbench for the stack machine executor: directed table, random programs, one fault.
`timescale 1ns / 1ps

module stack_machine_executor_tb
    import smx_pkg::*;
();

    // Run bounds
    localparam int CYCLE_LIMIT  = 500000;
    localparam int NUM_DIRECTED = 27;
    localparam int MAX_PRINTS   = 20;

    // One result as seen on the master channel
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
    } t_exec_result;

    // Directed row; rows with has_exp set carry a hand-worked result,
    // the others are checked against the shadow stack
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] value;
        logic              has_exp;
        t_exec_result      exp;
    } t_program_row;

    typedef enum int { MIX_BALANCED, MIX_GROW, MIX_SHRINK } t_op_mix;
    typedef enum int { FAULT_UNKNOWN, FAULT_UNDERFLOW, FAULT_OVERFLOW, FAULT_DIVZERO } t_fault;

    localparam t_program_row DIRECTED [NUM_DIRECTED] = '{
        '{OP_NONE, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0000_0000, 9'd0}},
        '{OP_PUSH, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h7FFF_FFFF, 9'd1}},
        '{OP_PUSH, 32'h0000_0001, 1'b1, '{ST_OK, 32'h0000_0001, 9'd2}},
        // max + 1 wraps to most negative
        '{OP_ADD,  32'h0000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 9'd1}},
        '{OP_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 9'd2}},
        // most negative / -1 wraps, remainder is zero
        '{OP_DIV,  32'h0000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 9'd1}},
        '{OP_PUSH, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 9'd2}},
        '{OP_MOD,  32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 9'd1}},
        '{OP_PUSH, 32'h8000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 9'd2}},
        '{OP_SUB,  32'h0000_0000, 1'b1, '{ST_OK, 32'h8000_0000, 9'd1}},
        '{OP_PUSH, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_MUL,  32'h0000_0000, 1'b0, '0},
        // negative dividend: truncation toward zero, remainder keeps sign
        '{OP_PUSH, 32'hFFFF_FFF9, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0002, 1'b0, '0},
        '{OP_DIV,  32'h0000_0000, 1'b0, '0},
        '{OP_PUSH, 32'hFFFF_FFF9, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0002, 1'b0, '0},
        '{OP_MOD,  32'h0000_0000, 1'b0, '0},
        '{OP_PUSH, 32'h0000_0003, 1'b0, '0},
        '{OP_DIV,  32'h0000_0000, 1'b0, '0},
        '{OP_PUSH, 32'h1234_5678, 1'b0, '0},
        '{OP_PUSH, 32'h9ABC_DEF0, 1'b0, '0},
        '{OP_MUL,  32'h0000_0000, 1'b0, '0},
        '{OP_POP,  32'h5A5A_5A5A, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 1'b0, '0},
        '{OP_POP,  32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 9'd0}}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic [ACT_W-1:0]       i_s_tuser   = '0;   // [3:0] action
    logic [WORD_W-1:0]      i_s_tdata   = '0;   // [31:0] push_value
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [STAT_W-1:0]      o_m_tuser;          // [2:0] status
    logic [OUT_TDATA_W-1:0] o_m_tdata;          // [31:0] top, [40:32] depth, [47:41] zero
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;

    // Shadow of the operand stack
    logic [WORD_W-1:0]  shadow_mem [STACK_DEPTH];
    logic [DEPTH_W-1:0] shadow_sp     = '0;
    logic               shadow_halted = 1'b0;

    t_exec_result pending_results [$];
    t_exec_result want_res;
    int           mismatch_count = 0;
    int           result_count   = 0;
    int           cycle_count    = 0;
    int           burst_left     = 1;

    stack_machine_executor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Executes one instruction on the shadow stack, returns what the block must report
    function automatic t_exec_result run_instruction(logic [ACT_W-1:0] action,
                                                     logic [WORD_W-1:0] value);
        t_exec_result      res;
        logic [WORD_W-1:0] opa, opb, outcome;
        logic signed [63:0] dividend, divisor, quot, rem;
        res.status = ST_OK;
        if (shadow_halted) begin
            res.status = ST_HALTED;
        end else begin
            case (action)
                OP_NONE: res.status = ST_OK;
                OP_PUSH: begin
                    if (shadow_sp >= STACK_DEPTH) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        shadow_mem[ADDR_W'(shadow_sp)] = value;
                        shadow_sp = shadow_sp + 1'b1;
                    end
                end
                OP_POP: begin
                    if (shadow_sp == 0) res.status = ST_UNDERFLOW;
                    else shadow_sp = shadow_sp - 1'b1;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                    if (shadow_sp < 2) begin
                        res.status = ST_UNDERFLOW;
                    end else begin
                        opb = shadow_mem[ADDR_W'(shadow_sp - 1'b1)];
                        opa = shadow_mem[ADDR_W'(shadow_sp - 2'd2)];
                        if ((action == OP_DIV || action == OP_MOD) && opb == 0) begin
                            res.status = ST_DIVZERO;
                        end else begin
                            // 64-bit signed math keeps most-negative / -1 defined
                            dividend = {{32{opa[31]}}, opa};
                            divisor  = {{32{opb[31]}}, opb};
                            quot     = (opb == 0) ? 64'sd0 : dividend / divisor;
                            rem      = (opb == 0) ? 64'sd0 : dividend % divisor;
                            case (action)
                                OP_ADD:  outcome = opa + opb;
                                OP_SUB:  outcome = opa - opb;
                                OP_MUL:  outcome = opa * opb;
                                OP_DIV:  outcome = quot[31:0];
                                default: outcome = rem[31:0];
                            endcase
                            shadow_sp = shadow_sp - 1'b1;
                            shadow_mem[ADDR_W'(shadow_sp - 1'b1)] = outcome;
                        end
                    end
                end
                default: res.status = ST_UNKNOWN;
            endcase
            if (res.status != ST_OK) shadow_halted = 1'b1;
        end
        res.top   = (shadow_sp != 0) ? shadow_mem[ADDR_W'(shadow_sp - 1'b1)] : '0;
        res.depth = shadow_sp;
        return res;
    endfunction

    // Operand values biased toward the corners and small divisors
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp);
        if (mismatch_count < MAX_PRINTS)
            $display("result %0d: %s mismatch, got %h expected %h", result_count, what, got, exp);
        mismatch_count++;
    endtask

    // Sends one request, holds it until taken, then books its expected result.
    // Valid stays high across a burst; it only drops when the burst ends.
    task automatic issue(logic [ACT_W-1:0] action, logic [WORD_W-1:0] value,
                         logic has_exp, t_exec_result exp);
        t_exec_result predicted;
        i_s_tuser  <= action;
        i_s_tdata  <= value;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = run_instruction(action, value);
        pending_results.push_back(has_exp ? exp : predicted);
        burst_left--;
        if (burst_left <= 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Sender holds off until the block has returned everything
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One random instruction that keeps the machine running
    task automatic random_step(t_op_mix mix);
        logic [ACT_W-1:0] act;
        int               push_pct;
        push_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 15 : 50;
        if ($urandom_range(0, 99) < push_pct) begin
            act = OP_PUSH;
        end else begin
            case ($urandom_range(0, 6))
                0:       act = OP_NONE;
                1:       act = OP_POP;
                2:       act = OP_ADD;
                3:       act = OP_SUB;
                4:       act = OP_MUL;
                5:       act = OP_DIV;
                default: act = OP_MOD;
            endcase
        end
        // steer away from the halting cases
        if (act == OP_PUSH && shadow_sp == STACK_DEPTH) act = OP_SUB;
        if (act == OP_POP && shadow_sp == 0) act = OP_PUSH;
        if (act >= OP_ADD && act <= OP_MOD && shadow_sp < 2) act = OP_PUSH;
        if ((act == OP_DIV || act == OP_MOD) &&
            shadow_mem[ADDR_W'(shadow_sp - 1'b1)] == 0)
            act = OP_MUL;
        issue(act, rand_word(), 1'b0, '0);
    endtask

    // Drives the stack into one error; the block then stays halted
    task automatic provoke_fault(t_fault kind);
        case (kind)
            FAULT_UNKNOWN: begin
                issue(ACT_W'($urandom_range(8, 15)), rand_word(), 1'b0, '0);
            end
            FAULT_UNDERFLOW: begin
                while (shadow_sp > 1) issue(OP_POP, rand_word(), 1'b0, '0);
                if ($urandom_range(0, 1) && shadow_sp != 0)
                    issue(OP_POP, rand_word(), 1'b0, '0);
                if (shadow_sp == 0 && $urandom_range(0, 1))
                    issue(OP_POP, rand_word(), 1'b0, '0);
                else
                    issue(ACT_W'($urandom_range(OP_ADD, OP_MOD)), rand_word(), 1'b0, '0);
            end
            FAULT_OVERFLOW: begin
                while (shadow_sp < STACK_DEPTH) issue(OP_PUSH, rand_word(), 1'b0, '0);
                issue(OP_PUSH, rand_word(), 1'b0, '0);
            end
            default: begin
                if (shadow_sp == STACK_DEPTH) issue(OP_POP, rand_word(), 1'b0, '0);
                if (shadow_sp == 0) issue(OP_PUSH, rand_word(), 1'b0, '0);
                issue(OP_PUSH, '0, 1'b0, '0);
                issue($urandom_range(0, 1) ? OP_DIV : OP_MOD, rand_word(), 1'b0, '0);
            end
        endcase
    endtask

    // Receiver: long always-ready stretches mixed with short stall/ready toggles
    initial begin
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(50, 300)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // Result checker; samples at the edge, so values are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unrequested result", {29'd0, o_m_tuser}, '0);
            end else begin
                want_res = pending_results.pop_front();
                if (o_m_tuser != want_res.status)
                    flag_mismatch("status", {29'd0, o_m_tuser}, {29'd0, want_res.status});
                if (o_m_tdata[WORD_W-1:0] != want_res.top)
                    flag_mismatch("top", o_m_tdata[WORD_W-1:0], want_res.top);
                if (o_m_tdata[WORD_W +: DEPTH_W] != want_res.depth)
                    flag_mismatch("depth", {23'd0, o_m_tdata[WORD_W +: DEPTH_W]},
                                  {23'd0, want_res.depth});
            end
            result_count++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stack_machine_executor_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed program: corners, every opcode, wrap cases
        for (int i = 0; i < NUM_DIRECTED; i++)
            issue(DIRECTED[i].action, DIRECTED[i].value, DIRECTED[i].has_exp, DIRECTED[i].exp);
        wait_for_results();

        // random programs: hover low, fill to the top, work full, drain
        repeat (150) random_step(MIX_BALANCED);
        while (shadow_sp < STACK_DEPTH) random_step(MIX_GROW);
        repeat (20) random_step(MIX_BALANCED);
        repeat (160) random_step(MIX_SHRINK);
        repeat (100) random_step(MIX_BALANCED);
        wait_for_results();

        // one error halts the block; everything after reports halted
        provoke_fault(t_fault'($urandom_range(0, 3)));
        repeat (20) issue(ACT_W'($urandom_range(0, 15)), rand_word(), 1'b0, '0);

        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("stack_machine_executor_tb: PASS");
        end else begin
            $display("stack_machine_executor_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/smx_pkg.sv
hw/rtl/smx_ram.sv
hw/rtl/stack_machine_executor.sv
sim/stack_machine_executor_tb.sv
